>>> rtl/tpm_pkg.sv
// ----------------------------------------------------------------------------
// tpm_pkg: shared types and codes for the trie prefix match core
// Result status codes, op codes and the command/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package tpm_pkg;

    typedef logic [1:0] status_t;

    localparam status_t ST_MATCHED  = 2'd0;
    localparam status_t ST_NOMATCH  = 2'd1;
    localparam status_t ST_INSERTED = 2'd2;
    localparam status_t ST_FULL     = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic    clear;
        logic    accept;
        logic    alloc;
        logic    follow;
        logic    set_overflow;
        logic    set_query_done;
        logic    rewind;
        logic    mark_leaf;
        logic    leaf_read;
        logic    emit;
        status_t emit_status;
    } tpm_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic op;
        logic last;
        logic query_done;
        logic overflow;
        logic sym_oob;
        logic link_valid;
        logic leaf_hit;
        logic pool_full;
        logic out_free;
    } tpm_sts_t;

endpackage

>>> rtl/trie_prefix_match_core.sv
// ----------------------------------------------------------------------------
// trie_prefix_match_core: character trie insert and prefix lookup
// Sequence: each accepted symbol beat registers its child link read, then the
//   step state updates the cursor and, on a result, loads the output register;
//   a lookup that walks through its last symbol adds a leaf read state first.
//   A result waits while the output register is still held, and no new symbol
//   beat is taken until the current one is done.
// Reset: the link table and leaf marks are swept clear, one entry a cycle,
//   with in_ready low.
// ----------------------------------------------------------------------------
module trie_prefix_match_core
    import tpm_pkg::*;
#(
    parameter int NODE_COUNT    = 256,
    parameter int ALPHABET_SIZE = 128,
    parameter int MODE_BITS     = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [6:0] symbol,
    input  logic       last_symbol,
    input  logic [7:0] entry_mode,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] match_mode
);

    tpm_cmd_t cmd;
    tpm_sts_t sts;

    tpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tpm_datapath #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .MODE_BITS     (MODE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .op          (op),
        .symbol      (symbol),
        .last_symbol (last_symbol),
        .entry_mode  (entry_mode),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .match_mode  (match_mode)
    );

endmodule

>>> rtl/tpm_ctrl.sv
// ----------------------------------------------------------------------------
// tpm_ctrl: sequencing state machine
// Runs the table clear after reset, takes one symbol beat at a time and
// decides the insert or lookup step from the datapath status.
// ----------------------------------------------------------------------------
module tpm_ctrl
    import tpm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  tpm_sts_t sts,
    output tpm_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_LEAF  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic    ov_hit;
    logic    step_alloc;
    logic    step_follow;
    logic    step_set_ov;
    logic    step_set_qd;
    logic    step_rewind;
    logic    step_mark;
    logic    step_emit;
    logic    to_leaf;
    status_t step_code;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        ov_hit      = 1'b0;
        step_alloc  = 1'b0;
        step_follow = 1'b0;
        step_set_ov = 1'b0;
        step_set_qd = 1'b0;
        step_rewind = 1'b0;
        step_mark   = 1'b0;
        step_emit   = 1'b0;
        to_leaf     = 1'b0;
        step_code   = ST_NOMATCH;

        if (sts.op == OP_INSERT)
        begin
            ov_hit = !sts.overflow && (sts.sym_oob || (!sts.link_valid && sts.pool_full));
            if (!sts.overflow && !ov_hit)
            begin
                step_alloc  = !sts.link_valid;
                step_follow = sts.link_valid;
            end
            step_set_ov = ov_hit;
            if (sts.last)
            begin
                step_emit   = 1'b1;
                step_code   = (sts.overflow || ov_hit) ? ST_FULL : ST_INSERTED;
                step_mark   = !(sts.overflow || ov_hit);
                step_rewind = 1'b1;
            end
        end
        else
        begin
            if (!sts.query_done)
            begin
                if (sts.leaf_hit)
                begin
                    step_emit   = 1'b1;
                    step_code   = ST_MATCHED;
                    step_set_qd = 1'b1;
                end
                else if (sts.sym_oob || !sts.link_valid)
                begin
                    step_emit   = 1'b1;
                    step_code   = ST_NOMATCH;
                    step_set_qd = 1'b1;
                end
                else
                begin
                    step_follow = 1'b1;
                    to_leaf     = sts.last;
                end
            end
            step_rewind = sts.last && !to_leaf;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!step_emit || sts.out_free)
                begin
                    cmd.alloc          = step_alloc;
                    cmd.follow         = step_follow;
                    cmd.set_overflow   = step_set_ov;
                    cmd.set_query_done = step_set_qd;
                    cmd.rewind         = step_rewind;
                    cmd.mark_leaf      = step_mark;
                    cmd.leaf_read      = to_leaf;
                    cmd.emit           = step_emit;
                    cmd.emit_status    = step_code;
                    state_next         = to_leaf ? S_LEAF : S_IDLE;
                end
            end
            S_LEAF:
            begin
                if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = sts.leaf_hit ? ST_MATCHED : ST_NOMATCH;
                    cmd.rewind      = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/tpm_datapath.sv
// ----------------------------------------------------------------------------
// tpm_datapath: node pool, cursor and result register
// Holds the child link table, leaf marks and modes, the string cursor and
// flags, the clear sweep counter and the registered output beat.
// ----------------------------------------------------------------------------
module tpm_datapath
    import tpm_pkg::*;
#(
    parameter int NODE_COUNT    = 256,
    parameter int ALPHABET_SIZE = 128,
    parameter int MODE_BITS     = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  tpm_cmd_t   cmd,
    output tpm_sts_t   sts,
    input  logic       op,
    input  logic [6:0] symbol,
    input  logic       last_symbol,
    input  logic [7:0] entry_mode,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] match_mode
);

    localparam int NODE_W    = $clog2(NODE_COUNT);
    localparam int SYM_W     = $clog2(ALPHABET_SIZE);
    localparam int SLOT_W    = NODE_W + SYM_W;
    localparam int SLOTS     = NODE_COUNT * (2 ** SYM_W);
    localparam int CNT_W     = $clog2(NODE_COUNT + 1);
    localparam int MW        = (MODE_BITS < 8) ? MODE_BITS : 8;
    localparam int SYM_EXT_W = (SYM_W > 7) ? SYM_W : 7;
    localparam int LINK_W    = NODE_W + 1;

    // link word: valid bit over child node index
    logic [LINK_W-1:0] child_mem [SLOTS];
    logic              mark_mem  [NODE_COUNT];
    logic [MW-1:0]     mode_mem  [NODE_COUNT];

    logic [LINK_W-1:0] link_rd_reg;
    logic              mark_rd_reg;
    logic [MW-1:0]     mode_rd_reg;

    logic              op_reg;
    logic [6:0]        sym_reg;
    logic              last_reg;
    logic [MW-1:0]     mode_reg;

    logic [NODE_W-1:0] cursor_reg, cursor_next;
    logic [CNT_W-1:0]  nodes_used_reg, nodes_used_next;
    logic              query_done_reg, query_done_next;
    logic              overflow_reg, overflow_next;
    logic [SLOT_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    status_t           status_reg;
    logic [7:0]        match_mode_reg;

    logic [SYM_EXT_W-1:0] sym_in_ext;
    logic [SYM_EXT_W-1:0] sym_reg_ext;
    logic [SLOT_W-1:0]    rd_slot;
    logic [SLOT_W-1:0]    wr_slot;
    logic [NODE_W-1:0]    link_node;
    logic [NODE_W-1:0]    end_node;
    logic [NODE_W-1:0]    leaf_rd_addr;
    logic                 out_free;

    assign sym_in_ext   = SYM_EXT_W'(symbol);
    assign sym_reg_ext  = SYM_EXT_W'(sym_reg);
    assign rd_slot      = {cursor_reg, sym_in_ext[SYM_W-1:0]};
    assign wr_slot      = {cursor_reg, sym_reg_ext[SYM_W-1:0]};
    assign link_node    = link_rd_reg[NODE_W-1:0];
    assign leaf_rd_addr = cmd.leaf_read ? link_node : cursor_reg;
    assign out_free     = !out_valid_reg || out_ready;

    always_comb
    begin
        if (cmd.alloc)
        begin
            end_node = nodes_used_reg[NODE_W-1:0];
        end
        else if (cmd.follow)
        begin
            end_node = link_node;
        end
        else
        begin
            end_node = cursor_reg;
        end
    end

    always_comb
    begin
        sts.clear_last = (clr_cnt_reg == SLOT_W'(SLOTS - 1));
        sts.op         = op_reg;
        sts.last       = last_reg;
        sts.query_done = query_done_reg;
        sts.overflow   = overflow_reg;
        sts.sym_oob    = ({2'b00, sym_reg} >= 9'(ALPHABET_SIZE));
        sts.link_valid = link_rd_reg[NODE_W];
        sts.leaf_hit   = mark_rd_reg;
        sts.pool_full  = (nodes_used_reg >= CNT_W'(NODE_COUNT));
        sts.out_free   = out_free;
    end

    always_comb
    begin
        cursor_next     = cmd.rewind ? '0 : end_node;
        nodes_used_next = cmd.alloc ? nodes_used_reg + 1'b1 : nodes_used_reg;
        clr_cnt_next    = cmd.clear ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

        if (cmd.rewind)
        begin
            query_done_next = 1'b0;
        end
        else if (cmd.set_query_done)
        begin
            query_done_next = 1'b1;
        end
        else
        begin
            query_done_next = query_done_reg;
        end

        if (cmd.rewind)
        begin
            overflow_next = 1'b0;
        end
        else if (cmd.set_overflow)
        begin
            overflow_next = 1'b1;
        end
        else
        begin
            overflow_next = overflow_reg;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            child_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.alloc)
        begin
            child_mem[wr_slot] <= {1'b1, nodes_used_reg[NODE_W-1:0]};
        end
        if (cmd.accept)
        begin
            link_rd_reg <= child_mem[rd_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mark_mem[clr_cnt_reg[NODE_W-1:0]] <= 1'b0;
        end
        else if (cmd.mark_leaf)
        begin
            mark_mem[end_node] <= 1'b1;
        end
        if (cmd.accept || cmd.leaf_read)
        begin
            mark_rd_reg <= mark_mem[leaf_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mark_leaf)
        begin
            mode_mem[end_node] <= mode_reg;
        end
        if (cmd.accept || cmd.leaf_read)
        begin
            mode_rd_reg <= mode_mem[leaf_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= op;
            sym_reg  <= symbol;
            last_reg <= last_symbol;
            mode_reg <= entry_mode[MW-1:0];
        end
        if (cmd.emit)
        begin
            status_reg     <= cmd.emit_status;
            match_mode_reg <= (cmd.emit_status == ST_MATCHED) ? 8'(mode_rd_reg) : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= '0;
            nodes_used_reg <= CNT_W'(1);
            query_done_reg <= 1'b0;
            overflow_reg   <= 1'b0;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cursor_reg     <= cursor_next;
            nodes_used_reg <= nodes_used_next;
            query_done_reg <= query_done_next;
            overflow_reg   <= overflow_next;
            clr_cnt_reg    <= clr_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign match_mode = match_mode_reg;

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result beat issued while output register still held");

    a_alloc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |-> !sts.pool_full && !overflow_reg)
        else $error("node allocated from an exhausted pool");

    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |=> nodes_used_reg == CNT_W'($past(nodes_used_reg) + 1'b1))
        else $error("node count did not advance on allocation");

    a_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rewind |=> cursor_reg == '0 && !query_done_reg && !overflow_reg)
        else $error("string state not rewound after last symbol");

endmodule
